// ===== design/bcmp_pkg.sv =====
// Shared types, widths and constants of the barometer compensation block.
`timescale 1ns / 1ps
package bcmp_pkg;

	localparam int unsigned RAW_W       = 20;
	localparam int unsigned DATA_W      = 32;
	localparam int unsigned WIDE_W      = 64;
	localparam int unsigned COEF_W      = 16;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = 64;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned SIDE_W      = 2 * DATA_W;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP       = 2'd0,
		REG_PRESS_LO   = 2'd1,
		REG_PRESS_HI   = 2'd2,
		REG_PRESS_NINE = 2'd3
	} reg_idx_t;

	// Arithmetic constants of the compensation formulas.
	localparam logic [WIDE_W-1:0] FINE_OFFSET  = 64'd128000;
	localparam logic [WIDE_W-1:0] PRESS_FULL   = 64'd1048576;
	localparam logic [WIDE_W-1:0] PRESS_SCALE  = 64'd3125;
	localparam logic [WIDE_W-1:0] PRESS_BIAS   = 64'h0000_8000_0000_0000;
	localparam logic [DATA_W-1:0] TEMP_ROUND   = 32'd128;

	// Unpacked calibration coefficients.
	typedef struct packed {
		logic [COEF_W-1:0] t1;
		logic [COEF_W-1:0] t2;
		logic [COEF_W-1:0] t3;
		logic [COEF_W-1:0] p1;
		logic [COEF_W-1:0] p2;
		logic [COEF_W-1:0] p3;
		logic [COEF_W-1:0] p4;
		logic [COEF_W-1:0] p5;
		logic [COEF_W-1:0] p6;
		logic [COEF_W-1:0] p7;
		logic [COEF_W-1:0] p8;
		logic [COEF_W-1:0] p9;
	} coef_t;

	// Item passed from the temperature front end to the pressure back end.
	typedef struct packed {
		logic [DATA_W-1:0] temp;
		logic [DATA_W-1:0] fine;
		logic [RAW_W-1:0]  adcp;
	} qitem_t;

endpackage

// ===== design/bcmp_if.sv =====
// Channel interfaces: reading pairs, results and configuration writes.
`timescale 1ns / 1ps
interface bcmp_sample_if;
	logic                          valid;
	logic                          ready;
	logic [bcmp_pkg::RAW_W-1:0]    raw_temperature;
	logic [bcmp_pkg::RAW_W-1:0]    raw_pressure;
	modport source (output valid, output raw_temperature, output raw_pressure, input ready);
	modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
	modport monitor (input valid, input raw_temperature, input raw_pressure, input ready);
endinterface

interface bcmp_result_if;
	logic                              valid;
	logic                              ready;
	logic signed [bcmp_pkg::DATA_W-1:0] temperature_centi;
	logic signed [bcmp_pkg::DATA_W-1:0] fine_temperature;
	logic [bcmp_pkg::DATA_W-1:0]        pressure_q24_8;
	logic                               pressure_invalid;
	modport source (output valid, output temperature_centi, output fine_temperature,
		output pressure_q24_8, output pressure_invalid, input ready);
	modport sink (input valid, input temperature_centi, input fine_temperature,
		input pressure_q24_8, input pressure_invalid, output ready);
	modport monitor (input valid, input temperature_centi, input fine_temperature,
		input pressure_q24_8, input pressure_invalid, input ready);
endinterface

interface bcmp_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [bcmp_pkg::CFG_IDX_W-1:0]    index;
	logic [bcmp_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
	modport monitor (input valid, input index, input data, input ready);
endinterface

// ===== design/bcmp_mul.sv =====
// Two-stage 64 by 64 bit multiplier keeping the low 64 bits of the product.
`timescale 1ns / 1ps
module bcmp_mul (
	input  logic                         clk,
	input  logic                         en,
	input  logic [bcmp_pkg::WIDE_W-1:0]  a,
	input  logic [bcmp_pkg::WIDE_W-1:0]  b,
	output logic [bcmp_pkg::WIDE_W-1:0]  p
);
	localparam int unsigned H = bcmp_pkg::WIDE_W / 2;

	logic [2*H-1:0] ll_s1;
	logic [H-1:0]   lh_s1;
	logic [H-1:0]   hl_s1;
	logic [2*H-1:0] ll_c;
	logic [2*H-1:0] lh_c;
	logic [2*H-1:0] hl_c;

	// Three half-width partial products; the high by high term falls off the top.
	always_comb begin
		ll_c = a[H-1:0] * b[H-1:0];
		lh_c = a[H-1:0] * b[2*H-1:H];
		hl_c = a[2*H-1:H] * b[H-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= ll_c;
			lh_s1 <= lh_c[H-1:0];
			hl_s1 <= hl_c[H-1:0];
			p     <= ll_s1 + {lh_s1 + hl_s1, {H{1'b0}}};
		end
	end
endmodule

// ===== design/bcmp_div.sv =====
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
`timescale 1ns / 1ps
module bcmp_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [bcmp_pkg::WIDE_W-1:0]  num,
	input  logic [bcmp_pkg::WIDE_W-1:0]  den,
	input  logic [bcmp_pkg::SIDE_W-1:0]  side_in,
	output logic [bcmp_pkg::WIDE_W-1:0]  quot,
	output logic [bcmp_pkg::SIDE_W-1:0]  side_out,
	output logic                         zero
);
	localparam int unsigned W = bcmp_pkg::WIDE_W;

	logic [W-1:0]                rem_s  [W+1];
	logic [W-1:0]                nq_s   [W+1];
	logic [W-1:0]                ad_s   [W+1];
	logic                        neg_s  [W+1];
	logic                        zero_s [W+1];
	logic [bcmp_pkg::SIDE_W-1:0] side_s [W+1];
	logic [W:0]                  trial_c [W];
	logic [W-1:0]                rem_c   [W];
	logic                        bit_c   [W];

	// Restoring step of every stage: shift in the next dividend bit and try a subtract.
	always_comb begin
		for (int i = 0; i < W; i++) begin
			trial_c[i] = {1'b0, rem_s[i][W-2:0], nq_s[i][W-1]} - {1'b0, ad_s[i]};
			bit_c[i]   = ~trial_c[i][W];
			rem_c[i]   = bit_c[i] ? trial_c[i][W-1:0] : {rem_s[i][W-2:0], nq_s[i][W-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Magnitudes and result sign.
			rem_s[0]  <= '0;
			nq_s[0]   <= num[W-1] ? (~num + 1'b1) : num;
			ad_s[0]   <= den[W-1] ? (~den + 1'b1) : den;
			neg_s[0]  <= num[W-1] ^ den[W-1];
			zero_s[0] <= (den == '0);
			side_s[0] <= side_in;
			for (int i = 0; i < W; i++) begin
				rem_s[i+1]  <= rem_c[i];
				nq_s[i+1]   <= {nq_s[i][W-2:0], bit_c[i]};
				ad_s[i+1]   <= ad_s[i];
				neg_s[i+1]  <= neg_s[i];
				zero_s[i+1] <= zero_s[i];
				side_s[i+1] <= side_s[i];
			end
			// Apply the sign; the most negative quotient wraps as in two's complement.
			quot     <= neg_s[W] ? (~nq_s[W] + 1'b1) : nq_s[W];
			side_out <= side_s[W];
			zero     <= zero_s[W];
		end
	end
endmodule

// ===== design/bcmp_fifo.sv =====
// Small queue between the temperature front end and the pressure back end.
`timescale 1ns / 1ps
module bcmp_fifo #(
	parameter int unsigned DEPTH = bcmp_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  bcmp_pkg::qitem_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output bcmp_pkg::qitem_t pop_data
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	bcmp_pkg::qitem_t mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end
endmodule

// ===== design/bcmp_front.sv =====
// Front end: accepts reading pairs and computes the 32-bit temperature terms.
`timescale 1ns / 1ps
module bcmp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  bcmp_pkg::coef_t  coef,
	bcmp_sample_if.sink      sample,
	output logic             push_valid,
	input  logic             push_ready,
	output bcmp_pkg::qitem_t push_data
);
	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic               en;
	logic [17:0]        x_c;
	logic [16:0]        d_c;
	logic signed [17:0] x_s1;
	logic signed [16:0] d_s1;
	logic signed [33:0] ap_c;
	logic signed [33:0] dd_c;
	logic signed [31:0] ap_s2;
	logic signed [31:0] dd_s2;
	logic signed [31:0] ddsh_c;
	logic signed [47:0] bm_c;
	logic signed [31:0] a_s3;
	logic signed [31:0] bm_s3;
	logic signed [31:0] bsh_c;
	logic signed [31:0] fine_s4;
	logic signed [31:0] t5_c;
	logic signed [31:0] temp_s5;
	logic signed [31:0] fine_s5;
	logic [bcmp_pkg::RAW_W-1:0] adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5;

	// The whole front pipeline moves when its last stage is empty or drains.
	assign en           = !v_s5 || push_ready;
	assign sample.ready = en;
	assign push_valid   = v_s5;
	assign push_data    = '{temp: temp_s5, fine: fine_s5, adcp: adcp_s5};

	// Temperature arithmetic, wrapping at 32 bits.
	always_comb begin
		x_c    = {1'b0, sample.raw_temperature[19:3]} - {1'b0, coef.t1, 1'b0};
		d_c    = {1'b0, sample.raw_temperature[19:4]} - {1'b0, coef.t1};
		ap_c   = x_s1 * $signed(coef.t2);
		dd_c   = d_s1 * d_s1;
		ddsh_c = dd_s2 >>> 12;
		bm_c   = ddsh_c * $signed(coef.t3);
		bsh_c  = bm_s3 >>> 14;
		t5_c   = {fine_s4[29:0], 2'b00} + fine_s4 + $signed(bcmp_pkg::TEMP_ROUND);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x_c;
			d_s1    <= d_c;
			adcp_s1 <= sample.raw_pressure;
			ap_s2   <= ap_c[31:0];
			dd_s2   <= dd_c[31:0];
			adcp_s2 <= adcp_s1;
			a_s3    <= ap_s2 >>> 11;
			bm_s3   <= bm_c[31:0];
			adcp_s3 <= adcp_s2;
			fine_s4 <= a_s3 + bsh_c;
			adcp_s4 <= adcp_s3;
			temp_s5 <= t5_c >>> 8;
			fine_s5 <= fine_s4;
			adcp_s5 <= adcp_s4;
		end
	end
endmodule

// ===== design/bcmp_back.sv =====
// Back end: 64-bit pressure formula with a pipelined divider and output register.
`timescale 1ns / 1ps
module bcmp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  bcmp_pkg::coef_t  coef,
	input  logic             in_valid,
	output logic             in_ready,
	input  bcmp_pkg::qitem_t in_item,
	bcmp_result_if.source    result
);
	localparam int unsigned W       = bcmp_pkg::WIDE_W;
	localparam int unsigned DIV_LAT = W + 2;
	localparam int unsigned PRE     = 9;
	localparam int unsigned POST    = 6;
	localparam int unsigned LAT     = PRE + DIV_LAT + POST;

	function automatic logic [W-1:0] sx16(input logic [bcmp_pkg::COEF_W-1:0] v);
		return {{(W - bcmp_pkg::COEF_W){v[bcmp_pkg::COEF_W-1]}}, v};
	endfunction

	logic                        vld_s [1:LAT];
	logic                        en;
	logic [bcmp_pkg::SIDE_W-1:0] tf_s [1:PRE];
	logic [bcmp_pkg::RAW_W-1:0]  adcp_s [1:6];
	logic [W-1:0] v1_s1;
	logic [W-1:0] vv, v1p5, v1p2, vvp6, vvp3, prod, num;
	logic [W-1:0] v1p5_s4, v1p5_s5, v1p2_s4, v1p2_s5;
	logic [W-1:0] vvp3_sh, prod_sh;
	logic [W-1:0] v2_s6, t_s6, numa_s7, den_s9, pfull_c;
	logic [W-1:0] quot, quot_sh, p9s, p8q, m6, m6_sh, p8q_sh, sum_sh;
	logic [W-1:0] q_t [1:4];
	logic [W-1:0] w2_s78, w2_s79, sum_s80, pr_c;
	logic [bcmp_pkg::SIDE_W-1:0] dside;
	logic [bcmp_pkg::SIDE_W-1:0] tf_t [1:POST];
	logic         dzero;
	logic         z_t [1:POST];
	logic [bcmp_pkg::DATA_W-1:0] pressure_s81;

	// Stall-all pipeline: it moves when the output register is empty or taken.
	assign en                       = !vld_s[LAT] || result.ready;
	assign in_ready                 = en;
	assign result.valid             = vld_s[LAT];
	assign result.temperature_centi = tf_t[POST][2*bcmp_pkg::DATA_W-1:bcmp_pkg::DATA_W];
	assign result.fine_temperature  = tf_t[POST][bcmp_pkg::DATA_W-1:0];
	assign result.pressure_q24_8    = pressure_s81;
	assign result.pressure_invalid  = z_t[POST];

	// Arithmetic right shifts, kept apart so that they stay signed.
	assign vvp3_sh = $signed(vvp3) >>> 8;
	assign prod_sh = $signed(prod) >>> 33;
	assign quot_sh = $signed(quot) >>> 13;
	assign m6_sh   = $signed(m6) >>> 25;
	assign p8q_sh  = $signed(p8q) >>> 19;
	assign sum_sh  = $signed(sum_s80) >>> 8;
	assign pfull_c = bcmp_pkg::PRESS_FULL - {{(W - bcmp_pkg::RAW_W){1'b0}}, adcp_s[6]};
	assign pr_c    = sum_sh + (sx16(coef.p7) << 4);

	// Multipliers ahead of the divider.
	bcmp_mul u_m_vv (.clk(clk), .en(en), .a(v1_s1), .b(v1_s1), .p(vv));
	bcmp_mul u_m_p5 (.clk(clk), .en(en), .a(v1_s1), .b(sx16(coef.p5)), .p(v1p5));
	bcmp_mul u_m_p2 (.clk(clk), .en(en), .a(v1_s1), .b(sx16(coef.p2)), .p(v1p2));
	bcmp_mul u_m_p6 (.clk(clk), .en(en), .a(vv), .b(sx16(coef.p6)), .p(vvp6));
	bcmp_mul u_m_p3 (.clk(clk), .en(en), .a(vv), .b(sx16(coef.p3)), .p(vvp3));
	bcmp_mul u_m_p1 (.clk(clk), .en(en), .a(t_s6),
		.b({{(W - bcmp_pkg::COEF_W){1'b0}}, coef.p1}), .p(prod));
	bcmp_mul u_m_sc (.clk(clk), .en(en), .a(numa_s7), .b(bcmp_pkg::PRESS_SCALE), .p(num));

	bcmp_div u_div (
		.clk(clk), .en(en), .num(num), .den(den_s9), .side_in(tf_s[PRE]),
		.quot(quot), .side_out(dside), .zero(dzero)
	);

	// Multipliers after the divider.
	bcmp_mul u_m_p9 (.clk(clk), .en(en), .a(sx16(coef.p9)), .b(quot_sh), .p(p9s));
	bcmp_mul u_m_p8 (.clk(clk), .en(en), .a(sx16(coef.p8)), .b(quot), .p(p8q));
	bcmp_mul u_m_sq (.clk(clk), .en(en), .a(p9s), .b($signed(q_t[2]) >>> 13), .p(m6));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int i = 2; i <= LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Entry and carried fields.
			v1_s1     <= {{(W - bcmp_pkg::DATA_W){in_item.fine[bcmp_pkg::DATA_W-1]}},
				in_item.fine} - bcmp_pkg::FINE_OFFSET;
			tf_s[1]   <= {in_item.temp, in_item.fine};
			adcp_s[1] <= in_item.adcp;
			for (int i = 2; i <= PRE; i++) begin
				tf_s[i] <= tf_s[i-1];
			end
			for (int i = 2; i <= 6; i++) begin
				adcp_s[i] <= adcp_s[i-1];
			end
			v1p5_s4 <= v1p5;
			v1p5_s5 <= v1p5_s4;
			v1p2_s4 <= v1p2;
			v1p2_s5 <= v1p2_s4;
			// Numerator and divisor terms.
			v2_s6   <= vvp6 + (v1p5_s5 << 17) + (sx16(coef.p4) << 35);
			t_s6    <= bcmp_pkg::PRESS_BIAS + vvp3_sh + (v1p2_s5 << 12);
			numa_s7 <= (pfull_c << 31) - v2_s6;
			den_s9  <= prod_sh;
			// Correction terms after the divide.
			q_t[1] <= quot;
			for (int i = 2; i <= 4; i++) begin
				q_t[i] <= q_t[i-1];
			end
			tf_t[1] <= dside;
			z_t[1]  <= dzero;
			for (int i = 2; i <= POST; i++) begin
				tf_t[i] <= tf_t[i-1];
				z_t[i]  <= z_t[i-1];
			end
			w2_s78       <= p8q_sh;
			w2_s79       <= w2_s78;
			sum_s80      <= q_t[4] + m6_sh + w2_s79;
			pressure_s81 <= z_t[POST-1] ? '0 : pr_c[bcmp_pkg::DATA_W-1:0];
		end
	end
endmodule

// ===== design/baro_temp_pressure_compensation_top.sv =====
// Top level of the barometer temperature and pressure compensation block.
//
//   Channel  Role    Payload                                              Handshake
//   sample   sink    raw_temperature, raw_pressure                         valid / ready
//   result   source  temperature_centi, fine_temperature, pressure_q24_8,  valid / ready
//                    pressure_invalid
//   cfg      sink    index, data (coefficient register writes)             valid / ready
//
// One reading pair is taken per clock while the front end is not stalled; the front
// end holds 5 stages, the queue one and the back end 81, most of them in the 64-stage
// one-bit-per-stage divider.
// Reset clears all valid bits and the coefficient registers; no clearing pass.
// A stalled result stops only the back end; the queue lets the front keep taking
// transactions until it fills.
`timescale 1ns / 1ps
module baro_temp_pressure_compensation_top #(
	parameter int unsigned QUEUE_DEPTH = bcmp_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	bcmp_sample_if.sink   sample,
	bcmp_result_if.source result,
	bcmp_cfg_if.sink      cfg
);
	logic [47:0]            temp_coef_q;
	logic [63:0]            press_lo_q;
	logic [63:0]            press_hi_q;
	logic [15:0]            press_nine_q;
	bcmp_pkg::coef_t        coef;
	logic                   push_valid, push_ready, pop_valid, pop_ready;
	bcmp_pkg::qitem_t       push_data, pop_data;

	assign cfg.ready = 1'b1;

	// Coefficient registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coef_q  <= '0;
			press_lo_q   <= '0;
			press_hi_q   <= '0;
			press_nine_q <= '0;
		end else if (cfg.valid) begin
			case (bcmp_pkg::reg_idx_t'(cfg.index))
				bcmp_pkg::REG_TEMP:       temp_coef_q  <= cfg.data[47:0];
				bcmp_pkg::REG_PRESS_LO:   press_lo_q   <= cfg.data;
				bcmp_pkg::REG_PRESS_HI:   press_hi_q   <= cfg.data;
				bcmp_pkg::REG_PRESS_NINE: press_nine_q <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	// Coefficient fields.
	assign coef = '{
		t1: temp_coef_q[15:0],  t2: temp_coef_q[31:16], t3: temp_coef_q[47:32],
		p1: press_lo_q[15:0],   p2: press_lo_q[31:16],  p3: press_lo_q[47:32],
		p4: press_lo_q[63:48],  p5: press_hi_q[15:0],   p6: press_hi_q[31:16],
		p7: press_hi_q[47:32],  p8: press_hi_q[63:48],  p9: press_nine_q
	};

	bcmp_front u_front (
		.clk(clk), .arst_n(arst_n), .coef(coef), .sample(sample),
		.push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
	);

	bcmp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
		.pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
	);

	bcmp_back u_back (
		.clk(clk), .arst_n(arst_n), .coef(coef),
		.in_valid(pop_valid), .in_ready(pop_ready), .in_item(pop_data), .result(result)
	);
endmodule

// ===== design/bcmp_checker.sv =====
// Port-level checker of the compensation block and its bind to the top level.
`timescale 1ns / 1ps
module bcmp_checker (
	input logic             clk,
	input logic             arst_n,
	bcmp_sample_if.sink     sample,
	bcmp_result_if.source   result,
	bcmp_cfg_if.sink        cfg
);
	logic signed [31:0] t5;
	logic signed [31:0] temp_exp;

	assign t5       = result.fine_temperature * 5 + 128;
	assign temp_exp = t5 >>> 8;

	// A waiting result stays offered.
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid)
		else $error("result valid dropped while stalled");

	// A waiting result keeps its pressure and temperature payload.
	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> $stable(result.pressure_q24_8)
			&& $stable(result.temperature_centi) && $stable(result.fine_temperature))
		else $error("result payload changed while stalled");

	// A zero divisor forces the pressure to zero.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.pressure_invalid |-> result.pressure_q24_8 == 32'd0)
		else $error("invalid pressure is not zero");

	// Temperature and fine temperature travel together through the queue and divider.
	a_temp_pair: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.temperature_centi == temp_exp)
		else $error("temperature does not match its fine temperature");

	// Register writes are never held off and the sample ready is known whenever a write is offered.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid |-> cfg.ready && !$isunknown(sample.ready))
		else $error("configuration write refused or sample ready unknown");
endmodule

bind baro_temp_pressure_compensation_top bcmp_checker u_bcmp_checker (
	.clk(clk), .arst_n(arst_n), .sample(sample), .result(result), .cfg(cfg)
);

// ===== verif/baro_temp_pressure_compensation_top_test.sv =====
// Self-checking testbench for the barometer temperature and pressure compensation top level.
`timescale 1ns / 1ps
module baro_temp_pressure_compensation_top_test;

	// One raw reading pair waiting to be driven.
	typedef struct {
		logic [bcmp_pkg::RAW_W-1:0] raw_t;
		logic [bcmp_pkg::RAW_W-1:0] raw_p;
	} raw_pair_t;

	// One compensated reading as the block should return it.
	typedef struct {
		logic [bcmp_pkg::DATA_W-1:0] temp;
		logic [bcmp_pkg::DATA_W-1:0] fine;
		logic [bcmp_pkg::DATA_W-1:0] press;
		logic                        inv;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bcmp_sample_if sample ();
	bcmp_result_if result ();
	bcmp_cfg_if    cfg ();

	baro_temp_pressure_compensation_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.result (result),
		.cfg    (cfg)
	);

	always #5 clk = ~clk;

	// Shadow copy of the coefficient registers.
	logic [47:0] temp_coefs  = '0;
	logic [63:0] press_lo    = '0;
	logic [63:0] press_hi    = '0;
	logic [15:0] press_nine  = '0;

	raw_pair_t pending_pairs[$];
	reading_t  expected_readings[$];
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned mismatches = 0;
	int unsigned readings_sent = 0;
	int unsigned readings_checked = 0;
	int unsigned invalid_seen = 0;

	function automatic logic [31:0] sar32(logic [31:0] v, int unsigned n);
		return $signed(v) >>> n;
	endfunction

	function automatic logic [63:0] sar64(logic [63:0] v, int unsigned n);
		return $signed(v) >>> n;
	endfunction

	function automatic logic [63:0] sx16(logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	// Signed division truncating toward zero; the most negative over -1 wraps.
	function automatic logic [63:0] div_trunc(logic [63:0] n, logic [63:0] d);
		logic [63:0] an, ad, q;
		an = n[63] ? -n : n;
		ad = d[63] ? -d : d;
		q  = an / ad;
		return (n[63] ^ d[63]) ? -q : q;
	endfunction

	// Integer compensation formulas: 32-bit temperature path, 64-bit pressure path.
	function automatic reading_t compensate(logic [bcmp_pkg::RAW_W-1:0] raw_t,
			logic [bcmp_pkg::RAW_W-1:0] raw_p);
		reading_t    r;
		logic [31:0] at, t1, t2, t3, x, a, d, b, fine;
		logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p;
		at = {12'b0, raw_t};
		t1 = {16'b0, temp_coefs[15:0]};
		t2 = {{16{temp_coefs[31]}}, temp_coefs[31:16]};
		t3 = {{16{temp_coefs[47]}}, temp_coefs[47:32]};
		x = (at >> 3) - (t1 << 1);
		a = sar32(x * t2, 11);
		d = (at >> 4) - t1;
		b = sar32(sar32(d * d, 12) * t3, 14);
		fine = a + b;
		r.fine = fine;
		r.temp = sar32(fine * 32'd5 + 32'd128, 8);

		p1 = {48'b0, press_lo[15:0]};
		p2 = sx16(press_lo[31:16]);
		p3 = sx16(press_lo[47:32]);
		p4 = sx16(press_lo[63:48]);
		p5 = sx16(press_hi[15:0]);
		p6 = sx16(press_hi[31:16]);
		p7 = sx16(press_hi[47:32]);
		p8 = sx16(press_hi[63:48]);
		p9 = sx16(press_nine);
		v1 = {{32{fine[31]}}, fine} - 64'd128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) << 17);
		v2 = v2 + (p4 << 35);
		v1 = sar64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
		v1 = sar64(((64'd1 << 47) + v1) * p1, 33);
		if (v1 == 64'd0) begin
			r.press = '0;
			r.inv   = 1'b1;
		end else begin
			p  = 64'd1048576 - {44'b0, raw_p};
			p  = div_trunc(((p << 31) - v2) * 64'd3125, v1);
			v1 = sar64(p9 * sar64(p, 13) * sar64(p, 13), 25);
			v2 = sar64(p8 * p, 19);
			p  = sar64(p + v1 + v2, 8) + (p7 << 4);
			r.press = p[31:0];
			r.inv   = 1'b0;
		end
		return r;
	endfunction

	// Sample and ready driver: next pending pair with random gaps; random result stalls.
	always @(posedge clk) begin : sample_driver
		raw_pair_t pair;
		if (!arst_n) begin
			sample.valid <= 1'b0;
			result.ready <= 1'b0;
		end else begin
			if (!sample.valid || sample.ready) begin
				if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					pair = pending_pairs.pop_front();
					sample.valid           <= 1'b1;
					sample.raw_temperature <= pair.raw_t;
					sample.raw_pressure    <= pair.raw_p;
				end else begin
					sample.valid <= 1'b0;
				end
			end
			result.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: predicts each accepted pair and checks each accepted result in order.
	always @(posedge clk) begin : result_monitor
		reading_t want;
		if (arst_n) begin
			if (sample.valid && sample.ready) begin
				expected_readings.push_back(compensate(sample.raw_temperature,
					sample.raw_pressure));
				readings_sent++;
			end
			if (result.valid && result.ready) begin
				if (expected_readings.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: result transaction with no reading outstanding");
				end else begin
					want = expected_readings.pop_front();
					readings_checked++;
					if (result.pressure_invalid)
						invalid_seen++;
					if (result.temperature_centi !== want.temp ||
							result.fine_temperature !== want.fine ||
							result.pressure_q24_8 !== want.press ||
							result.pressure_invalid !== want.inv) begin
						mismatches++;
						if (mismatches <= 10)
							$display("ERROR: reading %0d exp t=%0d f=%0d p=%h inv=%b got t=%0d f=%0d p=%h inv=%b",
								readings_checked, $signed(want.temp), $signed(want.fine),
								want.press, want.inv, result.temperature_centi,
								result.fine_temperature, result.pressure_q24_8,
								result.pressure_invalid);
					end
				end
			end
		end
	end

	// Writes one coefficient register and updates the shadow copy.
	task automatic write_reg(bcmp_pkg::reg_idx_t idx, logic [63:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			bcmp_pkg::REG_TEMP:       temp_coefs = val[47:0];
			bcmp_pkg::REG_PRESS_LO:   press_lo   = val;
			bcmp_pkg::REG_PRESS_HI:   press_hi   = val;
			bcmp_pkg::REG_PRESS_NINE: press_nine = val[15:0];
			default: ;
		endcase
	endtask

	task automatic write_all(logic [63:0] tc, logic [63:0] lo, logic [63:0] hi,
			logic [63:0] nine);
		write_reg(bcmp_pkg::REG_TEMP, tc);
		write_reg(bcmp_pkg::REG_PRESS_LO, lo);
		write_reg(bcmp_pkg::REG_PRESS_HI, hi);
		write_reg(bcmp_pkg::REG_PRESS_NINE, nine);
	endtask

	task automatic queue_pair(logic [bcmp_pkg::RAW_W-1:0] t, logic [bcmp_pkg::RAW_W-1:0] p);
		raw_pair_t pair;
		pair.raw_t = t;
		pair.raw_p = p;
		pending_pairs.push_back(pair);
	endtask

	// Random pairs: mostly near typical readings, the rest over the full range.
	task automatic queue_random(int unsigned count);
		repeat (count) begin
			if ($urandom_range(99) < 60)
				queue_pair(20'($urandom_range(560000, 480000)),
					20'($urandom_range(460000, 380000)));
			else
				queue_pair(20'($urandom_range(20'hFFFFF)), 20'($urandom_range(20'hFFFFF)));
		end
	endtask

	// Lets a phase drain completely, then idles before the next phase.
	task automatic drain_phase();
		while (pending_pairs.size() > 0 || sample.valid || expected_readings.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic set_idling(int unsigned mode);
		case (mode % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
			default: begin send_idle_pct = 34; recv_stall_pct = 34; end
		endcase
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Stimulus sequence: register settings, directed pairs, then random phases.
	initial begin
		sample.valid = 1'b0;
		sample.raw_temperature = '0;
		sample.raw_pressure = '0;
		result.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = bcmp_pkg::REG_TEMP;
		cfg.data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset coefficients: zero pressure divisor on every reading.
		set_idling(0);
		queue_pair(20'h00000, 20'h00000);
		queue_pair(20'hFFFFF, 20'hFFFFF);
		queue_random(30);
		drain_phase();

		// Typical calibration with directed readings at the field extremes.
		write_all(64'h0000_FC18_6743_6B70, {16'd2855, 16'd3024, 16'hD643, 16'd36477},
			{16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 64'd6000);
		set_idling(1);
		queue_pair(20'h00000, 20'h00000);
		queue_pair(20'hFFFFF, 20'hFFFFF);
		queue_pair(20'h00000, 20'hFFFFF);
		queue_pair(20'hFFFFF, 20'h00000);
		queue_pair(20'h80000, 20'h7FFFF);
		queue_pair(20'hAAAAA, 20'h55555);
		queue_pair(20'h55555, 20'hAAAAA);
		queue_pair(20'd519888, 20'd415148);
		queue_pair(20'd519888, 20'd1);
		queue_pair(20'd1, 20'd415148);
		queue_random(100);
		drain_phase();

		// All coefficient bits set, with junk above the narrow registers.
		write_all({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
		set_idling(2);
		queue_pair(20'h00000, 20'h00000);
		queue_pair(20'hFFFFF, 20'hFFFFF);
		queue_random(100);
		drain_phase();

		// Most negative signed coefficients, top bit of the unsigned ones.
		write_all(64'h0000_8000_8000_8000, 64'h8000_8000_8000_8000,
			64'h8000_8000_8000_8000, 64'h0000_0000_0000_8000);
		set_idling(3);
		queue_pair(20'h00000, 20'hFFFFF);
		queue_pair(20'hFFFFF, 20'h00000);
		queue_random(100);
		drain_phase();

		// Largest positive signed coefficients.
		write_all(64'h0000_7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_FFFF,
			64'h7FFF_7FFF_7FFF_7FFF, 64'h0000_0000_0000_7FFF);
		set_idling(0);
		queue_random(60);
		drain_phase();

		// Random calibrations; one with P1 cleared for the zero divisor.
		for (int ph = 0; ph < 4; ph++) begin
			write_all(rand64(), (ph == 2) ? (rand64() & ~64'hFFFF) : rand64(),
				rand64(), rand64());
			set_idling(ph + 1);
			queue_random(60);
			drain_phase();
		end

		$display("Checked %0d of %0d readings over 9 calibration settings and four idling modes,",
			readings_checked, readings_sent);
		$display("%0d with the zero-divisor flag; %0d mismatches.", invalid_seen, mismatches);
		if (mismatches == 0 && expected_readings.size() == 0) begin
			$display("PASS baro_temp_pressure_compensation_top");
		end else begin
			$display("FAIL baro_temp_pressure_compensation_top");
		end
		$finish;
	end

	// Hard limit on the run time.
	initial begin
		#3ms;
		$display("ERROR: timeout with %0d readings outstanding", expected_readings.size());
		$display("FAIL baro_temp_pressure_compensation_top");
		$finish;
	end

endmodule
